@@ rtl/olbg_pkg.sv @@
package olbg_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_COMMIT = 2'd1;
    localparam logic [1:0] FUNC_MAP    = 2'd2;
    localparam logic [1:0] FUNC_GAMMA  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_OUTPUTS  = 2'd0;
    localparam logic [1:0] CFG_BLEND_FRAMES = 2'd1;
    localparam logic [1:0] CFG_GAMMA_ENABLE = 2'd2;

    localparam int NUM_LANES   = 3;
    localparam int LANE_RED    = 0;
    localparam int LANE_GREEN  = 1;
    localparam int LANE_BLUE   = 2;
    localparam int BYTE_W      = 8;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LANE,
        ST_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        L_CLEAR,
        L_IDLE,
        L_ACC,
        L_LAST,
        L_DIV,
        L_GAMMA,
        L_DONE
    } lane_state_t;

    typedef struct packed {
        logic start;
        logic blend_on;
        logic gamma_on;
        logic lut_we;
    } lane_ctrl_t;

    typedef struct packed {
        logic ready;
        logic done;
    } lane_stat_t;

endpackage

@@ rtl/led_output_blend_gamma_top.sv @@
// LED output color stage: logical-to-physical mapping, temporal blend over
// up to MAX_FRAMES history frames, and a gamma table per color channel.
// Input words arrive on s_tvalid/s_tready; s_tuser selects set color,
// commit frame, load map entry or load gamma entry. Every input word yields
// exactly one result word on m_tvalid/m_tready: status on m_tuser, the
// physical slot, the blue/green/red bytes and the history frame pointer.
// Three channel lanes (red, green, blue) each hold their own history and
// gamma memories, sum the slot's history one frame per cycle, divide by the
// blend count bit-serially and look up gamma; a merge stage packs the lanes.
// Commit and load words go straight to the result register; a set word passes
// the map check and then the lanes: the history read loop and an 8-step divider
// when blending, then the gamma lookup.
// One word is in flight at a time; the next word is taken once the current
// one has moved into the result register, even while that result still waits.
// After reset the lanes sweep their history memories to zero, one entry per
// cycle, over all 2^(clog2(MAX_FRAMES) + clog2(min(MAX_LEDS, 256))) entries (2048
// at the defaults); s_tready stays low until then, config writes are taken anytime.
// A stalled receiver holds the result register and, one word later, the core.
module led_output_blend_gamma_top #(
    parameter int MAX_OUTPUTS = 256,
    parameter int MAX_LEDS    = 256,
    parameter int MAX_FRAMES  = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [7:0] output_index, [15:8] red, [23:16] green, [31:24] blue,
    // [32] map_present, [40:33] map_slot, [42:41] lut_channel,
    // [50:43] lut_address, [58:51] lut_word, [63:59] zero
    input  logic [olbg_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [1:0] func
    input  logic [1:0]                           s_tuser,
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] physical_slot, [15:8] byte_blue, [23:16] byte_green,
    // [31:24] byte_red, [34:32] frame_slot, [39:35] zero
    output logic [olbg_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // [0] status
    output logic                                 m_tuser,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_index,
    input  logic [olbg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int MAP_DEPTH = (MAX_OUTPUTS < 256) ? MAX_OUTPUTS : 256;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int LED_DEPTH = (MAX_LEDS < 256) ? MAX_LEDS : 256;
    localparam int LED_AW    = $clog2(LED_DEPTH);
    localparam int FRAME_AW  = $clog2(MAX_FRAMES);
    localparam int NW        = $clog2(MAX_FRAMES + 1);

    // Input word fields
    logic [7:0] in_idx, in_red, in_green, in_blue, in_mslot, in_laddr, in_lword;
    logic       in_present;
    logic [1:0] in_lch, in_func;

    assign in_idx     = s_tdata[7:0];
    assign in_red     = s_tdata[15:8];
    assign in_green   = s_tdata[23:16];
    assign in_blue    = s_tdata[31:24];
    assign in_present = s_tdata[32];
    assign in_mslot   = s_tdata[40:33];
    assign in_lch     = s_tdata[42:41];
    assign in_laddr   = s_tdata[50:43];
    assign in_lword   = s_tdata[58:51];
    assign in_func    = s_tuser;

    olbg_pkg::top_state_t state_reg, state_next;

    logic [8:0]          num_outputs_reg;
    logic [3:0]          blend_frames_reg;
    logic [2:0]          gamma_en_reg;
    logic [FRAME_AW-1:0] fp_reg;

    logic [7:0]          idx_reg;
    logic [7:0]          rgb_reg [olbg_pkg::NUM_LANES];
    logic                status_reg;
    logic                use_bytes_reg;
    logic [7:0]          res_slot_reg;

    logic [7:0]          map_mem [MAP_DEPTH];
    logic                map_vld_reg [MAP_DEPTH];
    logic [7:0]          map_rdata_reg;

    olbg_pkg::lane_ctrl_t lane_ctrl [olbg_pkg::NUM_LANES];
    olbg_pkg::lane_stat_t lane_stat [olbg_pkg::NUM_LANES];
    logic [olbg_pkg::BYTE_W-1:0] lane_byte [olbg_pkg::NUM_LANES];

    logic              accept;
    logic              lanes_ready;
    logic [NW-1:0]     blend_n;
    logic              in_idx_ok;
    logic              idx_ok;
    logic              map_ok;
    logic              lane_start;
    logic              merge_load;
    logic              merge_free;
    logic [MAP_AW-1:0] in_map_addr;
    logic [MAP_AW-1:0] map_addr;

    assign lanes_ready = lane_stat[olbg_pkg::LANE_RED].ready
                      && lane_stat[olbg_pkg::LANE_GREEN].ready
                      && lane_stat[olbg_pkg::LANE_BLUE].ready;
    assign s_tready    = (state_reg == olbg_pkg::ST_IDLE) && lanes_ready;
    assign accept      = s_tvalid && s_tready;

    // Blend count: below two means no blending, cap at the history depth
    assign blend_n = (blend_frames_reg < 4'd2) ? '0
                   : (32'(blend_frames_reg) > MAX_FRAMES) ? NW'(MAX_FRAMES)
                   : NW'(blend_frames_reg);

    assign in_map_addr = in_idx[MAP_AW-1:0];
    assign map_addr    = idx_reg[MAP_AW-1:0];
    assign in_idx_ok   = (32'(in_idx) < MAX_OUTPUTS);
    assign idx_ok      = ({1'b0, idx_reg} < num_outputs_reg) && (32'(idx_reg) < MAX_OUTPUTS);
    // Unmapped, out of range, or a slot past the strip all fail the set
    assign map_ok      = idx_ok && map_vld_reg[map_addr] && (32'(map_rdata_reg) < MAX_LEDS);

    // Map table: slot bytes in memory, presence bits in flops cleared at reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            map_rdata_reg <= map_mem[in_map_addr];
            if (in_func == olbg_pkg::FUNC_MAP && in_idx_ok) begin
                map_mem[in_map_addr] <= in_mslot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAP_DEPTH; i++) begin
                map_vld_reg[i] <= 1'b0;
            end
        end else if (accept && in_func == olbg_pkg::FUNC_MAP && in_idx_ok) begin
            map_vld_reg[in_map_addr] <= in_present;
        end
    end

    // Config registers and the frame pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_outputs_reg  <= '0;
            blend_frames_reg <= '0;
            gamma_en_reg     <= '0;
            fp_reg           <= '0;
        end else begin
            if (accept && in_func == olbg_pkg::FUNC_COMMIT && blend_n != '0) begin
                fp_reg <= (NW'(fp_reg) + NW'(1) == blend_n) ? '0 : fp_reg + FRAME_AW'(1);
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    olbg_pkg::CFG_NUM_OUTPUTS: num_outputs_reg <= cfg_wdata;
                    olbg_pkg::CFG_BLEND_FRAMES: begin
                        blend_frames_reg <= cfg_wdata[3:0];
                        fp_reg           <= '0;
                    end
                    olbg_pkg::CFG_GAMMA_ENABLE: gamma_en_reg <= cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olbg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        lane_start = 1'b0;
        merge_load = 1'b0;
        unique case (state_reg)
            olbg_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (in_func == olbg_pkg::FUNC_SET) ? olbg_pkg::ST_CHECK
                                                                 : olbg_pkg::ST_EMIT;
                end
            end
            olbg_pkg::ST_CHECK: begin
                lane_start = map_ok;
                state_next = map_ok ? olbg_pkg::ST_LANE : olbg_pkg::ST_EMIT;
            end
            olbg_pkg::ST_LANE: begin
                if (lane_stat[olbg_pkg::LANE_RED].done) state_next = olbg_pkg::ST_EMIT;
            end
            olbg_pkg::ST_EMIT: begin
                if (merge_free) begin
                    merge_load = 1'b1;
                    state_next = olbg_pkg::ST_IDLE;
                end
            end
            default: state_next = olbg_pkg::ST_IDLE;
        endcase
    end

    // Hold the word and build the result fields
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg                      <= in_idx;
            rgb_reg[olbg_pkg::LANE_RED]   <= in_red;
            rgb_reg[olbg_pkg::LANE_GREEN] <= in_green;
            rgb_reg[olbg_pkg::LANE_BLUE]  <= in_blue;
            status_reg                   <= 1'b0;
            use_bytes_reg                <= 1'b0;
            res_slot_reg                 <= '0;
        end else if (state_reg == olbg_pkg::ST_CHECK) begin
            status_reg    <= !map_ok;
            use_bytes_reg <= map_ok;
            res_slot_reg  <= map_ok ? map_rdata_reg : '0;
        end
    end

    for (genvar k = 0; k < olbg_pkg::NUM_LANES; k++) begin : g_lane
        always_comb begin
            lane_ctrl[k].start    = lane_start;
            lane_ctrl[k].blend_on = (blend_n != '0);
            lane_ctrl[k].gamma_on = gamma_en_reg[k];
            lane_ctrl[k].lut_we   = accept && (in_func == olbg_pkg::FUNC_GAMMA)
                                    && (in_lch == 2'(k));
        end

        olbg_lane #(
            .FRAME_AW (FRAME_AW),
            .LED_AW   (LED_AW),
            .NW       (NW)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl[k]),
            .slot     (map_rdata_reg[LED_AW-1:0]),
            .frame    (fp_reg),
            .count    (blend_n),
            .value    (rgb_reg[k]),
            .lut_addr (in_laddr),
            .lut_word (in_lword),
            .stat     (lane_stat[k]),
            .byte_out (lane_byte[k])
        );
    end

    olbg_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (merge_load),
        .status     (status_reg),
        .use_bytes  (use_bytes_reg),
        .slot       (res_slot_reg),
        .frame_slot (3'(fp_reg)),
        .lane_byte  (lane_byte),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .free       (merge_free)
    );

    // The frame pointer stays inside the blend window
    a_fp_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (blend_n != '0) |-> (NW'(fp_reg) < blend_n))
        else $error("frame pointer outside blend window");

    // Lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_stat[olbg_pkg::LANE_RED].done |->
            (lane_stat[olbg_pkg::LANE_GREEN].done && lane_stat[olbg_pkg::LANE_BLUE].done))
        else $error("channel lanes out of step");

    // One word at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while one is in flight");

    // A failed set carries no slot and no bytes
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'd0))
        else $error("failed set carries payload");

endmodule

@@ rtl/olbg_lane.sv @@
module olbg_lane #(
    parameter int FRAME_AW = 3,
    parameter int LED_AW   = 8,
    parameter int NW       = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  olbg_pkg::lane_ctrl_t      ctrl,
    input  logic [LED_AW-1:0]         slot,
    input  logic [FRAME_AW-1:0]       frame,
    input  logic [NW-1:0]             count,
    input  logic [olbg_pkg::BYTE_W-1:0] value,
    input  logic [7:0]                lut_addr,
    input  logic [olbg_pkg::BYTE_W-1:0] lut_word,
    output olbg_pkg::lane_stat_t      stat,
    output logic [olbg_pkg::BYTE_W-1:0] byte_out
);

    localparam int HAW    = FRAME_AW + LED_AW;
    localparam int HDEPTH = 1 << HAW;
    localparam int SW     = olbg_pkg::BYTE_W + NW;

    olbg_pkg::lane_state_t state_reg, state_next;

    logic [olbg_pkg::BYTE_W-1:0] hist_mem [HDEPTH];
    logic [olbg_pkg::BYTE_W-1:0] gamma_mem [256];

    logic [HAW-1:0]              clr_cnt_reg;
    logic [LED_AW-1:0]           slot_reg;
    logic [NW-1:0]               n_reg;
    logic [FRAME_AW-1:0]         rd_idx_reg;
    logic                        rd_vld_reg;
    logic [SW-1:0]               acc_reg;
    logic [NW-1:0]               rem_reg;
    logic [7:0]                  dq_reg;
    logic [2:0]                  div_cnt_reg;
    logic                        gamma_on_reg;
    logic [olbg_pkg::BYTE_W-1:0] hist_rdata_reg;
    logic [olbg_pkg::BYTE_W-1:0] g_rdata_reg;
    logic [olbg_pkg::BYTE_W-1:0] byte_reg;

    logic [SW-1:0]               sum;
    logic [NW:0]                 trial;
    logic                        ge;
    logic                        last_rd;
    logic                        hist_we;
    logic [HAW-1:0]              hist_waddr;
    logic [olbg_pkg::BYTE_W-1:0] hist_wdata;

    assign sum     = acc_reg + SW'(hist_rdata_reg);
    assign trial   = {rem_reg, dq_reg[7]};
    assign ge      = (trial >= {1'b0, n_reg});
    assign last_rd = (NW'(rd_idx_reg) == (n_reg - NW'(1)));

    // Single write port: clearing sweep or the new frame entry at start
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = clr_cnt_reg;
        hist_wdata = '0;
        if (state_reg == olbg_pkg::L_CLEAR) begin
            hist_we = 1'b1;
        end else if (state_reg == olbg_pkg::L_IDLE && ctrl.start && ctrl.blend_on) begin
            hist_we    = 1'b1;
            hist_waddr = {frame, slot};
            hist_wdata = value;
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[{rd_idx_reg, slot_reg}];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.lut_we) begin
            gamma_mem[lut_addr] <= lut_word;
        end
        g_rdata_reg <= gamma_mem[dq_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olbg_pkg::L_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            olbg_pkg::L_CLEAR: begin
                if (clr_cnt_reg == '1) state_next = olbg_pkg::L_IDLE;
            end
            olbg_pkg::L_IDLE: begin
                if (ctrl.start) begin
                    state_next = ctrl.blend_on ? olbg_pkg::L_ACC : olbg_pkg::L_GAMMA;
                end
            end
            olbg_pkg::L_ACC: begin
                if (last_rd) state_next = olbg_pkg::L_LAST;
            end
            olbg_pkg::L_LAST:  state_next = olbg_pkg::L_DIV;
            olbg_pkg::L_DIV: begin
                if (div_cnt_reg == 3'd7) state_next = olbg_pkg::L_GAMMA;
            end
            olbg_pkg::L_GAMMA: state_next = olbg_pkg::L_DONE;
            olbg_pkg::L_DONE:  state_next = olbg_pkg::L_IDLE;
            default:           state_next = olbg_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= (state_reg == olbg_pkg::L_ACC);
            if (state_reg == olbg_pkg::L_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + HAW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            olbg_pkg::L_IDLE: begin
                if (ctrl.start) begin
                    slot_reg     <= slot;
                    n_reg        <= count;
                    gamma_on_reg <= ctrl.gamma_on;
                    dq_reg       <= value;
                    rd_idx_reg   <= '0;
                    acc_reg      <= '0;
                end
            end
            olbg_pkg::L_ACC: begin
                rd_idx_reg <= rd_idx_reg + FRAME_AW'(1);
                if (rd_vld_reg) acc_reg <= sum;
            end
            olbg_pkg::L_LAST: begin
                // sum < 256 * n, so the upper part already sits below n
                rem_reg     <= sum[SW-1:8];
                dq_reg      <= sum[7:0];
                div_cnt_reg <= '0;
            end
            olbg_pkg::L_DIV: begin
                rem_reg     <= ge ? NW'(trial - {1'b0, n_reg}) : trial[NW-1:0];
                dq_reg      <= {dq_reg[6:0], ge};
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            olbg_pkg::L_DONE: begin
                byte_reg <= gamma_on_reg ? g_rdata_reg : dq_reg;
            end
            default: begin
            end
        endcase
    end

    assign stat.ready = (state_reg == olbg_pkg::L_IDLE);
    assign stat.done  = (state_reg == olbg_pkg::L_DONE);
    assign byte_out   = byte_reg;

endmodule

@@ rtl/olbg_merge.sv @@
module olbg_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  logic                                 status,
    input  logic                                 use_bytes,
    input  logic [7:0]                           slot,
    input  logic [2:0]                           frame_slot,
    input  logic [olbg_pkg::BYTE_W-1:0]          lane_byte [olbg_pkg::NUM_LANES],
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [olbg_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tuser,
    output logic                                 free
);

    logic                             m_tvalid_reg;
    logic [olbg_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                             m_tuser_reg;
    logic [olbg_pkg::BYTE_W-1:0]      red, green, blue;

    // Zero the bytes of anything but a successful set
    assign red   = use_bytes ? lane_byte[olbg_pkg::LANE_RED]   : '0;
    assign green = use_bytes ? lane_byte[olbg_pkg::LANE_GREEN] : '0;
    assign blue  = use_bytes ? lane_byte[olbg_pkg::LANE_BLUE]  : '0;

    assign free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {5'b0, frame_slot, red, green, blue, slot};
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ sim/led_output_blend_gamma_checker.sv @@
`timescale 1ns / 100ps

module led_output_blend_gamma_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [olbg_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [olbg_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_index,
    input  logic [olbg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               mismatches,
    output int                               words_pending
);

    localparam int MAP_DEPTH   = 256;
    localparam int HIST_FRAMES = 8;
    localparam int LED_SLOTS   = 256;

    typedef struct packed {
        logic       status;
        logic [7:0] slot;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [2:0] frame;
    } led_word_t;

    logic [8:0] map_entry   [MAP_DEPTH];
    logic [7:0] history     [olbg_pkg::NUM_LANES][HIST_FRAMES][LED_SLOTS];
    logic [7:0] gamma_table [olbg_pkg::NUM_LANES][256];
    int         frame_ptr;
    logic [8:0] num_outputs;
    logic [3:0] blend_frames;
    logic [2:0] gamma_enable;

    led_word_t  expected_led_words [$];

    function automatic int blend_count();
        if (blend_frames < 2)
            return 0;
        if (blend_frames > HIST_FRAMES)
            return HIST_FRAMES;
        return int'(blend_frames);
    endfunction

    // Advance the color stage by one input word and return its result word.
    function automatic led_word_t predict_led_word(logic [1:0] func,
                                                   logic [olbg_pkg::IN_TDATA_W-1:0] d);
        led_word_t  w;
        logic [7:0] idx;
        logic [7:0] slot;
        logic [7:0] lane_val [olbg_pkg::NUM_LANES];
        logic [1:0] lch;
        int         n;
        int         fp;
        int         sum;
        w = '0;
        idx = d[7:0];
        lane_val[olbg_pkg::LANE_RED]   = d[15:8];
        lane_val[olbg_pkg::LANE_GREEN] = d[23:16];
        lane_val[olbg_pkg::LANE_BLUE]  = d[31:24];
        lch = d[42:41];
        case (func)
            olbg_pkg::FUNC_SET: begin
                // 8-bit index and slot always sit inside the table and strip
                if (idx < num_outputs && map_entry[idx][8]) begin
                    slot = map_entry[idx][7:0];
                    n = blend_count();
                    if (n != 0) begin
                        fp = frame_ptr % n;
                        for (int l = 0; l < olbg_pkg::NUM_LANES; l++) begin
                            history[l][fp][slot] = lane_val[l];
                            sum = 0;
                            for (int f = 0; f < n; f++)
                                sum += history[l][f][slot];
                            lane_val[l] = 8'(sum / n);
                        end
                    end
                    for (int l = 0; l < olbg_pkg::NUM_LANES; l++)
                        if (gamma_enable[l])
                            lane_val[l] = gamma_table[l][lane_val[l]];
                    w.slot  = slot;
                    w.red   = lane_val[olbg_pkg::LANE_RED];
                    w.green = lane_val[olbg_pkg::LANE_GREEN];
                    w.blue  = lane_val[olbg_pkg::LANE_BLUE];
                end else begin
                    w.status = 1'b1;
                end
            end
            olbg_pkg::FUNC_COMMIT: begin
                n = blend_count();
                if (n != 0)
                    frame_ptr = (frame_ptr + 1) % n;
            end
            olbg_pkg::FUNC_MAP: begin
                map_entry[idx] = d[32] ? {1'b1, d[40:33]} : 9'd0;
            end
            default: begin
                if (lch < olbg_pkg::NUM_LANES)
                    gamma_table[lch][d[50:43]] = d[58:51];
            end
        endcase
        w.frame = 3'(frame_ptr);
        return w;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        led_word_t want;
        if (!aresetn) begin
            foreach (map_entry[i])
                map_entry[i] = '0;
            foreach (history[l, f, s])
                history[l][f][s] = '0;
            foreach (gamma_table[l, a])
                gamma_table[l][a] = '0;
            frame_ptr    = 0;
            num_outputs  = '0;
            blend_frames = '0;
            gamma_enable = '0;
            mismatches   = 0;
            expected_led_words.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_led_words.size() == 0) begin
                    $error("result word with no expectation waiting");
                    mismatches++;
                end else begin
                    want = expected_led_words.pop_front();
                    check_field("status", 8'(want.status), 8'(m_tuser));
                    check_field("physical_slot", want.slot, m_tdata[7:0]);
                    check_field("byte_blue", want.blue, m_tdata[15:8]);
                    check_field("byte_green", want.green, m_tdata[23:16]);
                    check_field("byte_red", want.red, m_tdata[31:24]);
                    check_field("frame_slot", 8'(want.frame), 8'(m_tdata[34:32]));
                end
            end
            if (s_tvalid && s_tready)
                expected_led_words.push_back(predict_led_word(s_tuser, s_tdata));
            if (cfg_wr_en) begin
                case (cfg_index)
                    olbg_pkg::CFG_NUM_OUTPUTS:  num_outputs = cfg_wdata[8:0];
                    olbg_pkg::CFG_BLEND_FRAMES: begin
                        blend_frames = cfg_wdata[3:0];
                        frame_ptr    = 0;
                    end
                    olbg_pkg::CFG_GAMMA_ENABLE: gamma_enable = cfg_wdata[2:0];
                    default: ;
                endcase
            end
        end
        words_pending = expected_led_words.size();
    end

endmodule

@@ sim/led_output_blend_gamma_top_test.sv @@
`timescale 1ns / 100ps

module led_output_blend_gamma_top_test;

    // Run length guard: sized from ~1300 words at worst-case blend latency,
    // heavy stalls on both sides, the long hold-off and the clearing sweep.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WORDS_PER_BLOCK = 42;

    // Every block input starts at a known value.
    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [olbg_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]                       s_tuser   = olbg_pkg::FUNC_SET;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [olbg_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tuser;
    logic                             cfg_wr_en = 1'b0;
    logic [1:0]                       cfg_index = olbg_pkg::CFG_NUM_OUTPUTS;
    logic [olbg_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Idle percentages for the two sides, changed per phase.
    int   send_idle_pct = 26;
    int   recv_idle_pct = 75;
    // Hold-off request from the stimulus; the receiver owns the countdown.
    logic hold_req      = 1'b0;
    int   hold_left     = 0;
    bit   hold_taken    = 1'b0;
    int   cycle_count   = 0;
    int   mismatches;
    int   words_pending;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    led_output_blend_gamma_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    led_output_blend_gamma_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    // Receiver: drive m_tready at the falling edge. A hold-off request drops
    // ready for a long counted stretch so the core and its result register
    // fill up and s_tready falls while the sender keeps offering words.
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("led_output_blend_gamma_top test failed");
            $finish;
        end
    end

    // Random filler for the bits an item does not use; top five bits stay zero.
    function automatic logic [olbg_pkg::IN_TDATA_W-1:0] random_payload();
        return {5'd0, 27'($urandom()), 32'($urandom())};
    endfunction

    // Offer one word from a falling edge and hold it until the block takes it.
    // Idle cycles go in front; each step assigns s_tvalid at most once.
    task automatic offer_word(input logic [1:0] func,
                              input logic [olbg_pkg::IN_TDATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_set(input logic [7:0] idx, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
        logic [olbg_pkg::IN_TDATA_W-1:0] d;
        d = random_payload();
        d[7:0]   = idx;
        d[15:8]  = red;
        d[23:16] = green;
        d[31:24] = blue;
        offer_word(olbg_pkg::FUNC_SET, d);
    endtask

    task automatic send_map(input logic [7:0] idx, input logic present,
                            input logic [7:0] slot);
        logic [olbg_pkg::IN_TDATA_W-1:0] d;
        d = random_payload();
        d[7:0]   = idx;
        d[32]    = present;
        d[40:33] = slot;
        offer_word(olbg_pkg::FUNC_MAP, d);
    endtask

    task automatic send_commit();
        offer_word(olbg_pkg::FUNC_COMMIT, random_payload());
    endtask

    task automatic send_gamma(input logic [1:0] lane, input logic [7:0] addr,
                              input logic [7:0] word);
        logic [olbg_pkg::IN_TDATA_W-1:0] d;
        d = random_payload();
        d[42:41] = lane;
        d[50:43] = addr;
        d[58:51] = word;
        offer_word(olbg_pkg::FUNC_GAMMA, d);
    endtask

    // Random word, mostly well-formed. Sets and map loads aim at a few hot
    // outputs and map loads at a few hot slots, so history slots get reused
    // and averages build up across frames. Loads to the missing fourth gamma
    // channel do nothing and are not counted.
    task automatic send_random_word(output bit counted);
        logic [1:0]                      fn;
        logic [olbg_pkg::IN_TDATA_W-1:0] d;
        int                              pick;
        d = random_payload();
        pick = $urandom_range(99);
        if (pick < 58)
            fn = olbg_pkg::FUNC_SET;
        else if (pick < 73)
            fn = olbg_pkg::FUNC_COMMIT;
        else if (pick < 88)
            fn = olbg_pkg::FUNC_MAP;
        else
            fn = olbg_pkg::FUNC_GAMMA;
        if ($urandom_range(9) < 8)
            d[7:0] = {$urandom_range(1) ? 5'h1F : 5'h00, 3'($urandom_range(7))};
        if (fn == olbg_pkg::FUNC_MAP) begin
            d[32] = ($urandom_range(9) != 0);
            if ($urandom_range(3) != 0)
                d[40:33] = {$urandom_range(1) ? 6'h3F : 6'h00, 2'($urandom_range(3))};
        end
        counted = !(fn == olbg_pkg::FUNC_GAMMA && d[42:41] >= olbg_pkg::NUM_LANES);
        offer_word(fn, d);
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (words_pending != 0)
            @(negedge aclk);
    endtask

    // Write the registers picked by mask on consecutive edges, then drop
    // the enable once.
    task automatic write_cfg(input logic [2:0] mask, input logic [8:0] num,
                             input logic [3:0] blend, input logic [2:0] gmask);
        logic [olbg_pkg::CFG_DATA_W-1:0] value [3];
        value[olbg_pkg::CFG_NUM_OUTPUTS]  = num;
        value[olbg_pkg::CFG_BLEND_FRAMES] = olbg_pkg::CFG_DATA_W'(blend);
        value[olbg_pkg::CFG_GAMMA_ENABLE] = olbg_pkg::CFG_DATA_W'(gmask);
        for (int i = olbg_pkg::CFG_NUM_OUTPUTS; i <= olbg_pkg::CFG_GAMMA_ENABLE; i++) begin
            if (mask[i]) begin
                cfg_wr_en <= 1'b1;
                cfg_index <= 2'(i);
                cfg_wdata <= value[i];
                @(negedge aclk);
            end
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int         sent;
        bit         took;
        logic [8:0] num;

        // Hold reset, then release it once for the whole run.
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Registers at reset: no outputs allowed, so any set is rejected.
        send_set(8'd0, 8'd1, 8'd2, 8'd3);
        wait_idle();
        write_cfg(3'b111, 9'd256, 4'd0, 3'd0);

        // Map the extreme outputs to the extreme slots; load one entry as
        // skipped. Then hit mapped, skipped and never-loaded outputs.
        send_map(8'd0, 1'b1, 8'd0);
        send_map(8'd255, 1'b1, 8'd255);
        send_map(8'd9, 1'b0, 8'd200);
        send_set(8'd0, 8'd255, 8'd0, 8'd128);
        send_set(8'd255, 8'd0, 8'd255, 8'd255);
        send_set(8'd9, 8'd10, 8'd20, 8'd30);
        send_set(8'd100, 8'd40, 8'd50, 8'd60);
        // Commit with blending off leaves the frame pointer alone.
        send_commit();

        // Index limit: outputs at or above num_outputs are rejected.
        wait_idle();
        write_cfg(3'b001, 9'd4, 4'd0, 3'd0);
        send_set(8'd4, 8'd7, 8'd7, 8'd7);
        send_map(8'd3, 1'b1, 8'd3);
        send_set(8'd3, 8'd255, 8'd255, 8'd255);

        // A blend count above the history depth clamps to eight frames.
        wait_idle();
        write_cfg(3'b011, 9'd256, 4'd15, 3'd0);
        send_set(8'd0, 8'd8, 8'd16, 8'd24);
        send_commit();
        send_set(8'd0, 8'd255, 8'd255, 8'd255);
        send_commit();

        // A blend count of one turns blending off; commit does nothing.
        wait_idle();
        write_cfg(3'b010, 9'd0, 4'd1, 3'd0);
        send_commit();
        send_set(8'd255, 8'd1, 8'd2, 8'd3);

        // Two frames: the pointer wraps back to zero on the second commit.
        wait_idle();
        write_cfg(3'b010, 9'd0, 4'd2, 3'd0);
        send_set(8'd0, 8'd200, 8'd100, 8'd50);
        send_commit();
        send_set(8'd0, 8'd55, 8'd155, 8'd255);
        send_commit();

        // A load to the fourth gamma channel is dropped.
        send_gamma(2'd3, 8'd0, 8'd255);

        // Fill every gamma entry before any table is switched on, so no
        // lookup ever lands on an unwritten entry.
        for (int lane = olbg_pkg::LANE_RED; lane <= olbg_pkg::LANE_BLUE; lane++)
            for (int a = 0; a < 256; a++)
                send_gamma(2'(lane), 8'(a), 8'($urandom_range(255)));
        wait_idle();
        write_cfg(3'b100, 9'd0, 4'd0, 3'd7);
        send_set(8'd0, 8'd0, 8'd0, 8'd0);
        send_set(8'd255, 8'd255, 8'd255, 8'd255);

        // Random part in three phases: slow receiver, slow sender, no idling.
        // Each phase runs in blocks with fresh register settings between them.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                wait_idle();
                if (phase == 0 && blk == 0) begin
                    write_cfg(3'b111, 9'd256, 4'd8, 3'd7);
                end else begin
                    case ($urandom_range(9))
                        0:       num = 9'd0;
                        1, 2, 3: num = 9'd256;
                        default: num = 9'($urandom_range(1, 255));
                    endcase
                    write_cfg(3'($urandom_range(1, 7)), num,
                              4'($urandom_range(15)), 3'($urandom_range(7)));
                end
                // Start the long receiver hold-off while words keep coming.
                if (phase == 0 && blk == 1)
                    hold_req = 1'b1;
                sent = 0;
                while (sent < WORDS_PER_BLOCK) begin
                    send_random_word(took);
                    sent += int'(took);
                end
            end
        end

        // Drain, let the pipeline settle, then give the verdict.
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("led_output_blend_gamma_top test passed");
        end else begin
            $display("led_output_blend_gamma_top test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/olbg_pkg.sv
rtl/olbg_lane.sv
rtl/olbg_merge.sv
rtl/led_output_blend_gamma_top.sv
sim/led_output_blend_gamma_checker.sv
sim/led_output_blend_gamma_top_test.sv
